// ===== rtl/core/ackermann_steering_command_macros.svh =====
// Assertion helpers; sampled on clk, disabled while arst_n is low.
`ifndef ACKERMANN_STEERING_COMMAND_MACROS_SVH
`define ACKERMANN_STEERING_COMMAND_MACROS_SVH

// Consequent checked in the same cycle.
`define ACC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("acc: assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ACC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("acc: assertion failed");

`endif

// ===== rtl/core/acc_pkg.sv =====
`timescale 1ns / 1ps
package acc_pkg;

	localparam int ANGLE_FRAC_BITS = 13;
	localparam int CORDIC_STEPS    = 16;
	localparam int ZFRAC           = 30;
	localparam int SHIFT           = ZFRAC - ANGLE_FRAC_BITS;
	localparam int STEP_W          = $clog2(CORDIC_STEPS);

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ANGLE_CAP   = (HALF_PI_Q30 + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;

	// datapath widths
	localparam int ROT_W  = 33;
	localparam int ROTZ_W = 15 + SHIFT + 2;
	localparam int PROD_W = 51;
	localparam int VEC_W  = 54;
	localparam int VZ_W   = 33;

	localparam int DIV_BITS  = 28;
	localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

	localparam int FIFO_DEPTH = 2;

	typedef enum logic [2:0] {
		REG_SPEED_LIMIT  = 3'd0,
		REG_STEER_LIMIT  = 3'd1,
		REG_WHEEL_RADIUS = 3'd2,
		REG_AXLE_BASE    = 3'd3,
		REG_TRACK        = 3'd4,
		REG_DUAL_STEER   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [14:0] speed_limit;
		logic [13:0] steer_limit;
		logic [15:0] wheel_radius_len;
		logic [15:0] axle_base_len;
		logic [15:0] track_len;
		logic        dual_steer;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] spd;
		logic signed [14:0] ang;
		logic               dual;
	} cmd_t;

	function automatic logic [30:0] atan_q30(input logic [4:0] idx);
		case (idx)
			5'd0:  atan_q30 = 31'd843314856;
			5'd1:  atan_q30 = 31'd497837829;
			5'd2:  atan_q30 = 31'd263043836;
			5'd3:  atan_q30 = 31'd133525158;
			5'd4:  atan_q30 = 31'd67021686;
			5'd5:  atan_q30 = 31'd33543515;
			5'd6:  atan_q30 = 31'd16775850;
			5'd7:  atan_q30 = 31'd8388437;
			5'd8:  atan_q30 = 31'd4194282;
			5'd9:  atan_q30 = 31'd2097149;
			5'd10: atan_q30 = 31'd1048575;
			5'd11: atan_q30 = 31'd524287;
			5'd12: atan_q30 = 31'd262143;
			5'd13: atan_q30 = 31'd131071;
			5'd14: atan_q30 = 31'd65535;
			5'd15: atan_q30 = 31'd32767;
			5'd16: atan_q30 = 31'd16383;
			5'd17: atan_q30 = 31'd8191;
			5'd18: atan_q30 = 31'd4095;
			5'd19: atan_q30 = 31'd2047;
			5'd20: atan_q30 = 31'd1023;
			5'd21: atan_q30 = 31'd511;
			5'd22: atan_q30 = 31'd255;
			5'd23: atan_q30 = 31'd127;
			default: atan_q30 = 31'd0;
		endcase
	endfunction

endpackage

// ===== rtl/core/acc_if.sv =====
`timescale 1ns / 1ps
interface acc_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] speed_cmd;
	logic signed [15:0] steer_cmd;
	modport source (output valid, speed_cmd, steer_cmd, input ready);
	modport sink (input valid, speed_cmd, steer_cmd, output ready);
	modport monitor (input valid, ready, speed_cmd, steer_cmd);
endinterface

interface acc_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] wheel_rate;
	logic signed [14:0] left_angle;
	logic signed [14:0] right_angle;
	modport source (output valid, wheel_rate, left_angle, right_angle, input ready);
	modport sink (input valid, wheel_rate, left_angle, right_angle, output ready);
	modport monitor (input valid, ready, wheel_rate, left_angle, right_angle);
endinterface

interface acc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
	modport monitor (input valid, ready, index, data);
endinterface

// ===== rtl/core/ackermann_steering_command.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake     payload
// cmd      in   valid/ready   speed_cmd, steer_cmd
// res      out  valid/ready   wheel_rate, left_angle, right_angle
// cfg      in   valid/ready   index, data (ready always high)
//
// Single-angle mode: an item's completion waits on the 28-step radius divider.
// Dual mode: 16 rotation steps, 3 products on one multiplier, a setup step and
// 16 vectoring steps on two lanes, plus load and output.
// A two-entry queue takes new items while the back end works or res stalls.
// Reset loads the default limits, radius, base, track and single-angle mode.
module ackermann_steering_command (
	input  logic      clk,
	input  logic      arst_n,
	acc_cmd_if.sink   cmd,
	acc_res_if.source res,
	acc_cfg_if.sink   cfg
);
	import acc_pkg::*;

	cfg_t cfg_q;
	logic full, push, not_empty, pop;
	cmd_t push_item, pop_item;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_limit      <= 15'd512;
			cfg_q.steer_limit      <= 14'd4096;
			cfg_q.wheel_radius_len <= 16'd410;
			cfg_q.axle_base_len    <= 16'd1638;
			cfg_q.track_len        <= 16'd819;
			cfg_q.dual_steer       <= 1'b0;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_SPEED_LIMIT:  cfg_q.speed_limit      <= cfg.data[14:0];
				REG_STEER_LIMIT:  cfg_q.steer_limit      <= cfg.data[13:0];
				REG_WHEEL_RADIUS: cfg_q.wheel_radius_len <= cfg.data;
				REG_AXLE_BASE:    cfg_q.axle_base_len    <= cfg.data;
				REG_TRACK:        cfg_q.track_len        <= cfg.data;
				REG_DUAL_STEER:   cfg_q.dual_steer       <= cfg.data[0];
				default: ;
			endcase
		end
	end

	acc_front u_front (
		.cmd       (cmd),
		.cfg       (cfg_q),
		.full      (full),
		.push      (push),
		.push_item (push_item)
	);

	acc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_item  (pop_item)
	);

	acc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (not_empty),
		.q_item  (pop_item),
		.q_pop   (pop),
		.res     (res)
	);
endmodule

// ===== rtl/core/acc_fifo.sv =====
`timescale 1ns / 1ps
module acc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  acc_pkg::cmd_t push_item,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output acc_pkg::cmd_t pop_item
);
	import acc_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	cmd_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ===== rtl/core/acc_front.sv =====
`timescale 1ns / 1ps
module acc_front (
	acc_cmd_if.sink       cmd,
	input  acc_pkg::cfg_t cfg,
	input  logic          full,
	output logic          push,
	output acc_pkg::cmd_t push_item
);
	import acc_pkg::*;

	logic signed [16:0] spd_lim, ang_lim, spd_in, ang_in, spd_c, ang_c;

	assign spd_lim = {2'b00, cfg.speed_limit};
	assign ang_lim = {3'b000, cfg.steer_limit};
	assign spd_in  = {cmd.speed_cmd[15], cmd.speed_cmd};
	assign ang_in  = {cmd.steer_cmd[15], cmd.steer_cmd};

	always_comb begin
		if (spd_in > spd_lim) begin
			spd_c = spd_lim;
		end else if (spd_in < -spd_lim) begin
			spd_c = -spd_lim;
		end else begin
			spd_c = spd_in;
		end
		if (ang_in > ang_lim) begin
			ang_c = ang_lim;
		end else if (ang_in < -ang_lim) begin
			ang_c = -ang_lim;
		end else begin
			ang_c = ang_in;
		end
	end

	assign cmd.ready      = !full;
	assign push           = cmd.valid && !full;
	assign push_item.spd  = spd_c[15:0];
	assign push_item.ang  = ang_c[14:0];
	assign push_item.dual = cfg.dual_steer && (ang_c != '0);
endmodule

// ===== rtl/core/acc_back.sv =====
`timescale 1ns / 1ps
module acc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  acc_pkg::cfg_t cfg,
	input  logic          q_valid,
	input  acc_pkg::cmd_t q_item,
	output logic          q_pop,
	acc_res_if.source     res
);
	import acc_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ROT   = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_SETUP = 6'b001000,
		ST_VEC   = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t                 state_q;
	cmd_t                   item_q;
	logic [STEP_W-1:0]      step_q;
	logic [1:0]             mul_cnt_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic [15:0]            rem_q;
	logic [DIV_BITS-1:0]    num_q;
	logic signed [ROT_W-1:0]  rx_q, ry_q;
	logic signed [ROTZ_W-1:0] rz_q;
	logic signed [PROD_W-1:0] p_bs_q, p_bc_q, p_ts_q;
	logic signed [VEC_W-1:0]  vx_q [2];
	logic signed [VEC_W-1:0]  vy_q [2];
	logic signed [VZ_W-1:0]   vz_q [2];
	logic                     dz_q [2];
	logic                     res_valid_q;
	logic signed [31:0]       rate_q;
	logic signed [14:0]       left_q, right_q;

	// loading a new item
	logic [14:0]              spd_mag;
	logic [DIV_BITS-1:0]      num_init;
	logic signed [ROTZ_W-1:0] z_ang;

	assign spd_mag  = q_item.spd[15] ? 15'(-q_item.spd) : q_item.spd[14:0];
	assign num_init = DIV_BITS'({spd_mag, 12'b0}) + DIV_BITS'(cfg.wheel_radius_len[15:1]);
	assign z_ang    = {{(ROTZ_W - 15){q_item.ang[14]}}, q_item.ang} <<< SHIFT;

	// restoring divider, one quotient bit per cycle
	logic [16:0] trial;
	logic        qbit;
	assign trial = {rem_q, num_q[DIV_BITS-1]};
	assign qbit  = (trial >= {1'b0, cfg.wheel_radius_len});

	// shared multiplier
	logic [16:0]              mul_a;
	logic signed [ROT_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;

	always_comb begin
		case (mul_cnt_q)
			2'd0:    begin mul_a = {cfg.axle_base_len, 1'b0}; mul_b = ry_q; end
			2'd1:    begin mul_a = {cfg.axle_base_len, 1'b0}; mul_b = rx_q; end
			default: begin mul_a = {1'b0, cfg.track_len};     mul_b = ry_q; end
		endcase
	end
	assign prod = $signed({1'b0, mul_a}) * mul_b;

	// wheel divisors
	logic signed [VEC_W-1:0] num_n, den [2];
	assign num_n  = VEC_W'(p_bs_q);
	assign den[0] = VEC_W'(p_bc_q) - VEC_W'(p_ts_q);
	assign den[1] = VEC_W'(p_bc_q) + VEC_W'(p_ts_q);

	logic signed [VZ_W-1:0] atan_step;
	assign atan_step = VZ_W'(atan_q30(5'(step_q)));

	function automatic logic signed [14:0] round_angle(input logic signed [VZ_W-1:0] z,
			input logic zero_div);
		logic [VZ_W-1:0] mag, rnd;
		logic [VZ_W-1:0] r;
		mag = z[VZ_W-1] ? VZ_W'(-z) : VZ_W'(z);
		rnd = mag + VZ_W'(longint'(1) <<< (SHIFT - 1));
		r   = rnd >> SHIFT;
		if (r > VZ_W'(ANGLE_CAP)) begin
			r = VZ_W'(ANGLE_CAP);
		end
		if (zero_div) begin
			round_angle = 15'(ANGLE_CAP);
		end else if (z[VZ_W-1]) begin
			round_angle = 15'(-r);
		end else begin
			round_angle = 15'(r);
		end
	endfunction

	logic out_free, fin_go;
	assign out_free  = !res_valid_q || res.ready;
	assign fin_go    = (state_q == ST_FIN) && out_free && (div_cnt_q == '0);
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign res.valid = res_valid_q;
	assign res.wheel_rate  = rate_q;
	assign res.left_angle  = left_q;
	assign res.right_angle = right_q;

	logic signed [31:0] rate_out;
	always_comb begin
		if (cfg.wheel_radius_len == '0) begin
			if (item_q.spd[15]) begin
				rate_out = 32'sh8000_0000;
			end else if (item_q.spd != '0) begin
				rate_out = 32'sh7FFF_FFFF;
			end else begin
				rate_out = '0;
			end
		end else if (item_q.spd[15]) begin
			rate_out = -$signed(32'(num_q));
		end else begin
			rate_out = $signed(32'(num_q));
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
			rem_q  <= '0;
			num_q  <= num_init;
			rx_q   <= '0;
			if (q_item.ang[14]) begin
				ry_q <= -ROT_W'(longint'(1) <<< ZFRAC);
				rz_q <= z_ang + ROTZ_W'(HALF_PI_Q30);
			end else begin
				ry_q <= ROT_W'(longint'(1) <<< ZFRAC);
				rz_q <= z_ang - ROTZ_W'(HALF_PI_Q30);
			end
		end else begin
			if (div_cnt_q != '0) begin
				rem_q <= qbit ? 16'(trial - {1'b0, cfg.wheel_radius_len}) : trial[15:0];
				num_q <= {num_q[DIV_BITS-2:0], qbit};
			end
			if (state_q == ST_ROT) begin
				if (!rz_q[ROTZ_W-1]) begin
					rx_q <= rx_q - (ry_q >>> step_q);
					ry_q <= ry_q + (rx_q >>> step_q);
					rz_q <= rz_q - ROTZ_W'(atan_q30(5'(step_q)));
				end else begin
					rx_q <= rx_q + (ry_q >>> step_q);
					ry_q <= ry_q - (rx_q >>> step_q);
					rz_q <= rz_q + ROTZ_W'(atan_q30(5'(step_q)));
				end
			end
		end
		if (state_q == ST_MUL) begin
			case (mul_cnt_q)
				2'd0:    p_bs_q <= prod;
				2'd1:    p_bc_q <= prod;
				default: p_ts_q <= prod;
			endcase
		end
		for (int l = 0; l < 2; l++) begin
			if (state_q == ST_SETUP) begin
				dz_q[l] <= (den[l] == '0);
				vx_q[l] <= den[l][VEC_W-1] ? -den[l] : den[l];
				vy_q[l] <= den[l][VEC_W-1] ? -num_n : num_n;
				vz_q[l] <= '0;
			end else if (state_q == ST_VEC) begin
				if (!vy_q[l][VEC_W-1]) begin
					vx_q[l] <= vx_q[l] + (vy_q[l] >>> step_q);
					vy_q[l] <= vy_q[l] - (vx_q[l] >>> step_q);
					vz_q[l] <= vz_q[l] + atan_step;
				end else begin
					vx_q[l] <= vx_q[l] - (vy_q[l] >>> step_q);
					vy_q[l] <= vy_q[l] + (vx_q[l] >>> step_q);
					vz_q[l] <= vz_q[l] - atan_step;
				end
			end
		end
		if (fin_go) begin
			rate_q <= rate_out;
			if (item_q.dual) begin
				left_q  <= round_angle(vz_q[0], dz_q[0]);
				right_q <= round_angle(vz_q[1], dz_q[1]);
			end else begin
				left_q  <= item_q.ang;
				right_q <= item_q.ang;
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			mul_cnt_q   <= '0;
			div_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (q_pop) begin
				div_cnt_q <= DIV_CNT_W'(DIV_BITS);
			end else if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					step_q    <= '0;
					mul_cnt_q <= '0;
					if (q_pop) begin
						state_q <= q_item.dual ? ST_ROT : ST_FIN;
					end
				end
				ST_ROT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					mul_cnt_q <= mul_cnt_q + 1'b1;
					if (mul_cnt_q == 2'd2) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					step_q  <= '0;
					state_q <= ST_VEC;
				end
				ST_VEC: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/acc_checker.sv =====
`timescale 1ns / 1ps
`include "ackermann_steering_command_macros.svh"
module acc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic               cfg_ready,
	input logic signed [31:0] wheel_rate,
	input logic signed [14:0] left_angle,
	input logic signed [14:0] right_angle
);
	`ACC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(wheel_rate) && $stable(left_angle) && $stable(right_angle))
	`ACC_ASSERT_NOW(a_res_known, res_valid, !$isunknown({wheel_rate, left_angle, right_angle}))
	`ACC_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)
endmodule

bind ackermann_steering_command acc_checker u_acc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.cfg_ready   (cfg.ready),
	.wheel_rate  (res.wheel_rate),
	.left_angle  (res.left_angle),
	.right_angle (res.right_angle)
);
